>>> src/nfc_pkg.sv
// Package with the mode codes, format constants and rounding helpers of the float converter.
package nfc_pkg;

    typedef enum logic [2:0] {
        MODE_BF16_TO_F32 = 3'd0,
        MODE_F32_TO_BF16 = 3'd1,
        MODE_F16_TO_F32  = 3'd2,
        MODE_F32_TO_F16  = 3'd3,
        MODE_E4M3_TO_F32 = 3'd4,
        MODE_F32_TO_E4M3 = 3'd5,
        MODE_E5M2_TO_F32 = 3'd6,
        MODE_F32_TO_E5M2 = 3'd7
    } mode_t;

    // Float32 magnitude patterns used as thresholds.
    localparam logic [30:0] F32_INF          = 31'h7f800000;
    localparam logic [31:0] F32_QNAN         = 32'h7fc00000;
    localparam logic [30:0] F16_OVF_MAG      = 31'h47800000;
    localparam logic [30:0] F16_MIN_NORM     = 31'h38800000;
    localparam logic [30:0] E4M3_SAT_MAG     = 31'h43e00000;
    localparam logic [30:0] E4M3_UNDER_MAG   = 31'h3a800000;
    localparam logic [30:0] E4M3_MIN_NORM    = 31'h3c800000;
    localparam logic [30:0] E5M2_OVF_MAG     = 31'h47700000;
    localparam logic [30:0] E5M2_UNDER_MAG   = 31'h37000000;

    // Narrow encodings of the special values, without sign.
    localparam logic [14:0] F16_QNAN         = 15'h7e00;
    localparam logic [14:0] F16_INF          = 15'h7c00;
    localparam logic [6:0]  FP8_NAN          = 7'h7f;
    localparam logic [6:0]  E4M3_MAX         = 7'h7e;
    localparam logic [6:0]  E5M2_MAX_FINITE  = 7'h7b;
    localparam logic [6:0]  E5M2_INF         = 7'h7c;
    localparam logic [15:0] BF16_QUIET_BIT   = 16'h0040;
    localparam logic [31:0] BF16_ROUND_BIAS  = 32'h00007fff;

    // Largest useful right shift: anything beyond rounds a 24-bit value to zero.
    localparam logic [8:0]  MAX_SHIFT        = 9'd25;

    // Right shift with round to nearest, ties to even.
    function automatic logic [31:0] rne_shift(logic [31:0] m, logic [4:0] s);
        logic [31:0] q;
        logic [31:0] rest;
        logic [31:0] half;
        logic        inc;
        q    = m >> s;
        rest = m & ((32'd1 << s) - 32'd1);
        half = (s == 5'd0) ? 32'd0 : (32'd1 << (s - 5'd1));
        inc  = (rest > half) || ((rest == half) && q[0]);
        if (s == 5'd0) begin
            return m;
        end
        return q + {31'd0, inc};
    endfunction

    // Narrow a finite magnitude below the overflow threshold.
    function automatic logic [31:0] narrow_mag(logic [30:0] mag, logic [4:0] norm_shift,
                                               logic [7:0] rebias, logic [7:0] k,
                                               logic [30:0] min_norm);
        logic [7:0]  be;
        logic [23:0] mm;
        logic [8:0]  s_full;
        logic [4:0]  s;
        be = mag[30:23];
        mm = {1'b1, mag[22:0]};
        if (be == 8'd0) begin
            be = 8'd1;
            mm = {1'b0, mag[22:0]};
        end
        s_full = 9'd150 - {1'b0, k} - {1'b0, be};
        s      = (s_full > MAX_SHIFT) ? MAX_SHIFT[4:0] : s_full[4:0];
        if (mag >= min_norm) begin
            return rne_shift({1'b0, mag} - {1'b0, rebias, 23'd0}, norm_shift);
        end
        return rne_shift({8'd0, mm}, s);
    endfunction

    // Widen a nonzero narrow denormal of value man * 2^-k to a float32 magnitude.
    function automatic logic [30:0] widen_denorm(logic [9:0] man, logic [7:0] k);
        logic [4:0]  p;
        logic [7:0]  e;
        logic [22:0] frac;
        p = 5'd0;
        for (int i = 0; i < 10; i++) begin
            if (man[i]) begin
                p = 5'(i);
            end
        end
        e    = 8'd127 + {3'd0, p} - k;
        frac = {13'd0, man} << (5'd23 - p);
        return {e, frac};
    endfunction

endpackage

>>> src/narrow_float_convert.sv
// Top level of the float32 / narrow float converter with its two-stage pipeline.
//
// Usage: the block converts one value per request between float32 bit
// patterns and a narrow format. The mode register, written through
// cfg_wr_en / cfg_wr_data, selects bfloat16, float16, fp8 e4m3 or fp8 e5m2
// and the direction. Write it only while no request is in flight.
// The input channel (s_valid / s_ready) carries the value and a last flag;
// the result channel (m_valid / m_ready) returns the converted bits, narrow
// results zero-extended to 32 bits, with the last flag copied through.
// The accepting edge loads the input register; the result register loads
// from it once the result stage is free, and m_valid then rises. One pass
// of logic gives one request per cycle while m_ready is held high.
// When the receiver stalls, the result register holds its request and the
// input register fills; s_ready drops only when both stages are occupied.
// A synchronous active-low reset empties both stages and sets the mode to
// bfloat16 to float32.
module narrow_float_convert (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_value,
    input  logic        s_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_result,
    output logic        m_last_out
);

    nfc_pkg::mode_t mode_reg;

    logic        in_valid_reg;
    logic [31:0] in_value_reg;
    logic        in_last_reg;

    logic        out_valid_reg;
    logic [31:0] out_result_reg;
    logic        out_last_reg;

    logic        out_free;
    logic        in_adv;
    logic [31:0] result_next;

    // Conversion intermediates.
    logic [31:0] v;
    logic [30:0] mag;
    logic        is_nan;
    logic [31:0] bf16_sum;
    logic [31:0] nar;

    // The result stage can take a new request when it is empty or being drained.
    assign out_free = !out_valid_reg || m_ready;
    assign in_adv   = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    assign m_valid    = out_valid_reg;
    assign m_result   = out_result_reg;
    assign m_last_out = out_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= nfc_pkg::MODE_BF16_TO_F32;
        end else if (cfg_wr_en) begin
            mode_reg <= nfc_pkg::mode_t'(cfg_wr_data);
        end
    end

    // Input register stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_value_reg <= s_value;
            in_last_reg  <= s_last;
        end
    end

    // Result register stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_adv) begin
            out_result_reg <= result_next;
            out_last_reg   <= in_last_reg;
        end
    end

    // Conversion logic between the two registers.
    always_comb begin
        v           = in_value_reg;
        mag         = v[30:0];
        is_nan      = mag > nfc_pkg::F32_INF;
        bf16_sum    = v + nfc_pkg::BF16_ROUND_BIAS + {31'd0, v[16]};
        nar         = 32'd0;
        result_next = 32'd0;
        unique case (mode_reg)
            nfc_pkg::MODE_BF16_TO_F32: begin
                result_next = {v[15:0], 16'd0};
            end
            nfc_pkg::MODE_F32_TO_BF16: begin
                if (is_nan) begin
                    result_next = {16'd0, v[31:16] | nfc_pkg::BF16_QUIET_BIT};
                end else begin
                    result_next = {16'd0, bf16_sum[31:16]};
                end
            end
            nfc_pkg::MODE_F16_TO_F32: begin
                if (v[14:10] == 5'h1f) begin
                    result_next = {v[15], 8'hff, v[9:0], 13'd0};
                end else if (v[14:10] == 5'd0) begin
                    result_next = (v[9:0] == 10'd0) ? {v[15], 31'd0}
                                : {v[15], nfc_pkg::widen_denorm(v[9:0], 8'd24)};
                end else begin
                    // Exponent rebias by 112 on the five-bit field.
                    result_next = {v[15], {3'd0, v[14:10]} + 8'd112, v[9:0], 13'd0};
                end
            end
            nfc_pkg::MODE_F32_TO_F16: begin
                if (is_nan) begin
                    result_next = {16'd0, v[31], nfc_pkg::F16_QNAN};
                end else if (mag >= nfc_pkg::F16_OVF_MAG) begin
                    result_next = {16'd0, v[31], nfc_pkg::F16_INF};
                end else begin
                    nar = nfc_pkg::narrow_mag(mag, 5'd13, 8'd112, 8'd24,
                                              nfc_pkg::F16_MIN_NORM);
                    result_next = {16'd0, v[31], nar[14:0]};
                end
            end
            nfc_pkg::MODE_E4M3_TO_F32: begin
                if (v[6:0] == 7'h7f) begin
                    result_next = {v[7], 31'd0} | nfc_pkg::F32_QNAN;
                end else if (v[6:3] == 4'd0) begin
                    result_next = (v[2:0] == 3'd0) ? {v[7], 31'd0}
                                : {v[7], nfc_pkg::widen_denorm({7'd0, v[2:0]}, 8'd9)};
                end else begin
                    result_next = {v[7], {4'd0, v[6:3]} + 8'd120, v[2:0], 20'd0};
                end
            end
            nfc_pkg::MODE_F32_TO_E4M3: begin
                if (is_nan) begin
                    result_next = {24'd0, v[31], nfc_pkg::FP8_NAN};
                end else if (mag >= nfc_pkg::E4M3_SAT_MAG) begin
                    result_next = {24'd0, v[31], nfc_pkg::E4M3_MAX};
                end else if (mag < nfc_pkg::E4M3_UNDER_MAG) begin
                    result_next = {24'd0, v[31], 7'd0};
                end else begin
                    nar = nfc_pkg::narrow_mag(mag, 5'd20, 8'd120, 8'd9,
                                              nfc_pkg::E4M3_MIN_NORM);
                    result_next = (nar > {25'd0, nfc_pkg::E4M3_MAX})
                                ? {24'd0, v[31], nfc_pkg::E4M3_MAX}
                                : {24'd0, v[31], nar[6:0]};
                end
            end
            nfc_pkg::MODE_E5M2_TO_F32: begin
                if (v[6:2] == 5'h1f) begin
                    // A NaN gets the quiet bit; its high payload bit lands on that same bit.
                    result_next = {v[7], 8'hff, (v[1:0] != 2'd0), v[0], 21'd0};
                end else if (v[6:2] == 5'd0) begin
                    result_next = (v[1:0] == 2'd0) ? {v[7], 31'd0}
                                : {v[7], nfc_pkg::widen_denorm({8'd0, v[1:0]}, 8'd16)};
                end else begin
                    result_next = {v[7], {3'd0, v[6:2]} + 8'd112, v[1:0], 21'd0};
                end
            end
            nfc_pkg::MODE_F32_TO_E5M2: begin
                if (is_nan) begin
                    result_next = {24'd0, v[31], nfc_pkg::FP8_NAN};
                end else if (mag >= nfc_pkg::E5M2_OVF_MAG) begin
                    result_next = {24'd0, v[31], nfc_pkg::E5M2_INF};
                end else if (mag < nfc_pkg::E5M2_UNDER_MAG) begin
                    result_next = {24'd0, v[31], 7'd0};
                end else begin
                    nar = nfc_pkg::narrow_mag(mag, 5'd21, 8'd112, 8'd16,
                                              nfc_pkg::F16_MIN_NORM);
                    result_next = (nar > {25'd0, nfc_pkg::E5M2_MAX_FINITE})
                                ? {24'd0, v[31], nfc_pkg::E5M2_INF}
                                : {24'd0, v[31], nar[6:0]};
                end
            end
            default: begin
                result_next = 32'd0;
            end
        endcase
    end

endmodule
